// ===== design/wed_pkg.sv =====
package wed_pkg;

  localparam int unsigned WEIGHT_W = 7;
  localparam int unsigned FLOOR_W  = 4;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned ID_W     = 11;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [ID_W-1:0]     CALL_BASE_ID = 11'h700;
  localparam logic [DATA_W-1:0]   ASCII_ZERO   = 8'h30;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 7'd127;

  localparam logic [WEIGHT_W-1:0] CAR_WEIGHT_RST  = 7'd10;
  localparam logic [WEIGHT_W-1:0] HALL_WEIGHT_RST = 7'd1;

  // signed travel direction codes
  localparam logic [DIR_W-1:0] DIR_STOP = 2'b00;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

  // input item kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_MSG  = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_CAR_WEIGHT  = 1'b0;
  localparam logic REG_HALL_WEIGHT = 1'b1;

endpackage

// ===== design/weighted_elevator_dispatcher_top.sv =====
// weighted elevator dispatcher
//
// input channel (in_valid/in_ready): one beat per item. req_type selects a
// one-second tick or a received call message (msg_id, data_byte). a car call
// (msg_id 0x700, ascii floor digit in data_byte) adds car_weight to that
// floor's request counter, a hall call (msg_id 0x700+floor) adds
// hall_weight; counters saturate at 127. a bad floor or id sets call_ignored.
// on a tick the car picks a direction from the request sums below and above
// it, moves one floor, or opens the door on a requested floor when stopped.
// output channel (out_valid/out_ready): one result beat per input beat with
// floor, move_dir, door_open and call_ignored.
// result path: an accepted beat lands in the input register and moves into
// the result register once that is free or being drained. throughput is one
// beat per cycle while out_ready is high. stalls: when out_ready is low the
// result holds and one more beat is still taken into the input register;
// in_ready drops only when both are full. reset (rst, synchronous): counters
// cleared, car at floor 1, stopped, weights back to 10 and 1, both stages
// empty. config writes go through the apb port (car weight at 0x0, hall weight
// at 0x4); the user writes only while idle, which the block does not check.
module weighted_elevator_dispatcher_top #(
  parameter int unsigned NUM_FLOORS = 9
) (
  input  logic                             clk,
  input  logic                             rst,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wed_pkg::APB_AW-1:0]       paddr,
  input  logic [wed_pkg::APB_DW-1:0]       pwdata,
  output logic [wed_pkg::APB_DW-1:0]       prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             req_type,
  input  logic [wed_pkg::ID_W-1:0]         msg_id,
  input  logic [wed_pkg::DATA_W-1:0]       data_byte,
  // output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wed_pkg::FLOOR_W-1:0]      floor,
  output logic signed [wed_pkg::DIR_W-1:0] move_dir,
  output logic                             door_open,
  output logic                             call_ignored
);

  localparam int unsigned IDX_W = $clog2(NUM_FLOORS);
  localparam int unsigned SUM_W = wed_pkg::WEIGHT_W + $clog2(NUM_FLOORS);
  localparam logic [wed_pkg::DATA_W-1:0] CAR_MAX =
    wed_pkg::DATA_W'(wed_pkg::ASCII_ZERO + NUM_FLOORS);
  localparam logic [wed_pkg::ID_W-1:0] HALL_MAX =
    wed_pkg::ID_W'(wed_pkg::CALL_BASE_ID + NUM_FLOORS);
  localparam logic [wed_pkg::FLOOR_W-1:0] TOP_FLOOR =
    wed_pkg::FLOOR_W'(NUM_FLOORS);

  // config registers
  logic [wed_pkg::WEIGHT_W-1:0] car_weight;
  logic [wed_pkg::WEIGHT_W-1:0] hall_weight;

  // dispatcher state
  logic [wed_pkg::WEIGHT_W-1:0] req_weight [NUM_FLOORS];
  logic [wed_pkg::WEIGHT_W-1:0] req_weight_next [NUM_FLOORS];
  logic [wed_pkg::FLOOR_W-1:0]  cur_floor;
  logic [wed_pkg::FLOOR_W-1:0]  cur_floor_next;
  logic [wed_pkg::DIR_W-1:0]    travel_dir;
  logic [wed_pkg::DIR_W-1:0]    travel_dir_next;

  // input register
  logic                         s1_valid;
  logic                         s1_req_type;
  logic [wed_pkg::ID_W-1:0]     s1_msg_id;
  logic [wed_pkg::DATA_W-1:0]   s1_data_byte;

  // result register
  logic door_open_next;
  logic call_ignored_next;
  logic advance;

  // ---------------------------------------------------------------------------
  // apb config port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      car_weight  <= wed_pkg::CAR_WEIGHT_RST;
      hall_weight <= wed_pkg::HALL_WEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        wed_pkg::REG_CAR_WEIGHT:  car_weight  <= pwdata[wed_pkg::WEIGHT_W-1:0];
        wed_pkg::REG_HALL_WEIGHT: hall_weight <= pwdata[wed_pkg::WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      wed_pkg::REG_CAR_WEIGHT:
        prdata = wed_pkg::APB_DW'(car_weight);
      wed_pkg::REG_HALL_WEIGHT:
        prdata = wed_pkg::APB_DW'(hall_weight);
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: the input register moves on whenever the result slot is free
  // or being drained, so one beat is buffered behind a stalled result
  // ---------------------------------------------------------------------------
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_type  <= req_type;
      s1_msg_id    <= msg_id;
      s1_data_byte <= data_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // single pass over the buffered beat
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [wed_pkg::DATA_W-1:0]   car_off;
    logic [wed_pkg::ID_W-1:0]     hall_off;
    logic [wed_pkg::FLOOR_W-1:0]  call_floor;
    logic [wed_pkg::WEIGHT_W-1:0] call_amount;
    logic                         call_hit;
    logic [wed_pkg::WEIGHT_W:0]   sat_sum;
    logic [SUM_W-1:0]             up_sum;
    logic [SUM_W-1:0]             down_sum;
    logic [wed_pkg::FLOOR_W-1:0]  floor_num;
    logic [IDX_W-1:0]             here_idx;
    logic [wed_pkg::FLOOR_W-1:0]  here_off;

    car_off           = s1_data_byte - wed_pkg::ASCII_ZERO;
    hall_off          = s1_msg_id - wed_pkg::CALL_BASE_ID;
    call_floor        = '0;
    call_amount       = '0;
    call_hit          = 1'b0;
    sat_sum           = '0;
    up_sum            = '0;
    down_sum          = '0;
    floor_num         = '0;
    here_off          = cur_floor - wed_pkg::FLOOR_W'(1);
    here_idx          = here_off[IDX_W-1:0];
    req_weight_next   = req_weight;
    cur_floor_next    = cur_floor;
    travel_dir_next   = travel_dir;
    door_open_next    = 1'b0;
    call_ignored_next = 1'b0;

    if (s1_req_type == wed_pkg::REQ_MSG) begin
      if (s1_msg_id == wed_pkg::CALL_BASE_ID) begin
        if (s1_data_byte > wed_pkg::ASCII_ZERO && s1_data_byte <= CAR_MAX) begin
          call_hit    = 1'b1;
          call_floor  = car_off[wed_pkg::FLOOR_W-1:0];
          call_amount = car_weight;
        end else begin
          call_ignored_next = 1'b1;
        end
      end else if (s1_msg_id > wed_pkg::CALL_BASE_ID && s1_msg_id <= HALL_MAX) begin
        call_hit    = 1'b1;
        call_floor  = hall_off[wed_pkg::FLOOR_W-1:0];
        call_amount = hall_weight;
      end else begin
        call_ignored_next = 1'b1;
      end

      // saturating add on the addressed counter
      for (int i = 0; i < NUM_FLOORS; i++) begin
        floor_num = wed_pkg::FLOOR_W'(i + 1);
        if (call_hit && call_floor == floor_num) begin
          sat_sum = {1'b0, req_weight[i]} + {1'b0, call_amount};
          req_weight_next[i] = sat_sum[wed_pkg::WEIGHT_W] ? wed_pkg::WEIGHT_MAX
                                                          : sat_sum[wed_pkg::WEIGHT_W-1:0];
        end
      end
    end else begin
      // request totals on each side of the car
      for (int i = 0; i < NUM_FLOORS; i++) begin
        floor_num = wed_pkg::FLOOR_W'(i + 1);
        if (floor_num < cur_floor) begin
          down_sum = down_sum + SUM_W'(req_weight[i]);
        end else if (floor_num > cur_floor) begin
          up_sum = up_sum + SUM_W'(req_weight[i]);
        end
      end

      case (travel_dir)
        wed_pkg::DIR_UP: begin
          if (up_sum != '0)        travel_dir_next = wed_pkg::DIR_UP;
          else if (down_sum != '0) travel_dir_next = wed_pkg::DIR_DOWN;
          else                     travel_dir_next = wed_pkg::DIR_STOP;
        end
        wed_pkg::DIR_DOWN: begin
          if (down_sum != '0)      travel_dir_next = wed_pkg::DIR_DOWN;
          else if (up_sum != '0)   travel_dir_next = wed_pkg::DIR_UP;
          else                     travel_dir_next = wed_pkg::DIR_STOP;
        end
        default: begin
          // stopped: heavier side wins, up on a nonzero tie
          if (down_sum > up_sum)   travel_dir_next = wed_pkg::DIR_DOWN;
          else if (up_sum != '0)   travel_dir_next = wed_pkg::DIR_UP;
          else                     travel_dir_next = wed_pkg::DIR_STOP;
        end
      endcase

      if (travel_dir_next == wed_pkg::DIR_UP && cur_floor < TOP_FLOOR) begin
        cur_floor_next = cur_floor + wed_pkg::FLOOR_W'(1);
      end else if (travel_dir_next == wed_pkg::DIR_DOWN
                   && cur_floor > wed_pkg::FLOOR_W'(1)) begin
        cur_floor_next = cur_floor - wed_pkg::FLOOR_W'(1);
      end

      // stopped on a requested floor: open and clear
      if (travel_dir_next == wed_pkg::DIR_STOP && req_weight[here_idx] != '0) begin
        req_weight_next[here_idx] = '0;
        door_open_next            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FLOORS; i++) begin
        req_weight[i] <= '0;
      end
      cur_floor  <= wed_pkg::FLOOR_W'(1);
      travel_dir <= wed_pkg::DIR_STOP;
    end else if (advance) begin
      req_weight <= req_weight_next;
      cur_floor  <= cur_floor_next;
      travel_dir <= travel_dir_next;
    end
  end

  // result register; floor and direction come straight from the state, which
  // only changes when a new result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      door_open    <= door_open_next;
      call_ignored <= call_ignored_next;
    end
  end

  assign floor    = cur_floor;
  assign move_dir = travel_dir;

`ifndef NO_ASSERTIONS
  a_floor_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_floor >= wed_pkg::FLOOR_W'(1) && cur_floor <= TOP_FLOOR)
    else $error("car floor out of range");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    travel_dir == wed_pkg::DIR_STOP || travel_dir == wed_pkg::DIR_UP
    || travel_dir == wed_pkg::DIR_DOWN)
    else $error("bad travel direction code");

  a_door_when_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && door_open |-> travel_dir == wed_pkg::DIR_STOP && !call_ignored)
    else $error("door opened while moving or on a message");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(cur_floor) && $stable(travel_dir))
    else $error("state changed without a beat");

  a_result_after_beat: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without a buffered beat");
`endif

endmodule

// ===== dv/weighted_elevator_dispatcher_top_tb.sv =====
module weighted_elevator_dispatcher_top_tb;
  import wed_pkg::*;

  localparam int unsigned NUM_FLOORS  = 9;
  localparam int          CLK_PERIOD  = 12;
  localparam int          MAX_IDLE    = 11;
  // worst drain: long output hold plus a full stall per queued beat
  localparam int          DRAIN_LIMIT = 3000;
  localparam int          HOLD_CYCLES = 80;
  localparam int          PHASE_BEATS = 315;
  localparam int          PARK_LIMIT  = 40;
  // hard run bound, kept with a wide margin over the slowest legal run
  localparam int          RUN_LIMIT   = 600000;

  // one input beat: a tick or a received call message
  typedef struct packed {
    logic              req_type;
    logic [ID_W-1:0]   msg_id;
    logic [DATA_W-1:0] data_byte;
  } call_beat_t;

  // one result beat as the car looks after that input
  typedef struct packed {
    logic [FLOOR_W-1:0]      floor;
    logic signed [DIR_W-1:0] move_dir;
    logic                    door_open;
    logic                    call_ignored;
  } car_view_t;

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_AW-1:0]       paddr;
  logic [APB_DW-1:0]       pwdata;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;
  logic                    in_valid;
  logic                    in_ready;
  logic                    req_type;
  logic [ID_W-1:0]         msg_id;
  logic [DATA_W-1:0]       data_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic [FLOOR_W-1:0]      floor;
  logic signed [DIR_W-1:0] move_dir;
  logic                    door_open;
  logic                    call_ignored;

  weighted_elevator_dispatcher_top #(
    .NUM_FLOORS(NUM_FLOORS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .msg_id      (msg_id),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .floor       (floor),
    .move_dir    (move_dir),
    .door_open   (door_open),
    .call_ignored(call_ignored)
  );

  // car state as the testbench expects it, advanced at each accepted input beat
  logic [WEIGHT_W-1:0] floor_weight [1:NUM_FLOORS];
  logic [FLOOR_W-1:0]  car_floor;
  logic [DIR_W-1:0]    car_dir;
  logic [WEIGHT_W-1:0] car_wt_cfg;
  logic [WEIGHT_W-1:0] hall_wt_cfg;

  // predicted result beats, oldest first
  car_view_t predicted_car_q [$];

  // idle controls for the driver and the result monitor
  bit tx_idle_en     = 1'b1;
  bit rx_idle_en     = 1'b1;
  int rx_hold_cycles = 0;

  // run statistics
  int mismatch_count      = 0;
  int beats_sent          = 0;
  int results_checked     = 0;
  int doors_opened        = 0;
  int ignored_calls       = 0;
  int saturated_adds      = 0;
  int weight_settings     = 0;
  int input_stall_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #(CLK_PERIOD * RUN_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // count cycles where the block pushes back on the input side
  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) input_stall_cycles++;
  end

  // saturating add into one floor counter
  function automatic void add_call_weight(int unsigned fl, logic [WEIGHT_W-1:0] w);
    int unsigned total;
    total = floor_weight[fl] + w;
    if (total > WEIGHT_MAX) begin
      floor_weight[fl] = WEIGHT_MAX;
      saturated_adds++;
    end else begin
      floor_weight[fl] = total[WEIGHT_W-1:0];
    end
  endfunction

  // advance the expected car state by one input beat and return the result beat
  function automatic car_view_t next_car_view(call_beat_t b);
    car_view_t   v;
    int unsigned up_sum;
    int unsigned down_sum;
    int unsigned id;
    int unsigned digit;
    int unsigned fl;
    v        = '0;
    up_sum   = 0;
    down_sum = 0;
    id       = b.msg_id;
    digit    = b.data_byte;
    if (b.req_type == REQ_MSG) begin
      // car call carries an ascii digit, hall call encodes the floor in the id
      if (id == CALL_BASE_ID) begin
        if (digit > ASCII_ZERO && digit <= ASCII_ZERO + NUM_FLOORS) begin
          add_call_weight(digit - ASCII_ZERO, car_wt_cfg);
        end else begin
          v.call_ignored = 1'b1;
        end
      end else if (id > CALL_BASE_ID && id <= CALL_BASE_ID + NUM_FLOORS) begin
        add_call_weight(id - CALL_BASE_ID, hall_wt_cfg);
      end else begin
        v.call_ignored = 1'b1;
      end
      if (v.call_ignored) ignored_calls++;
    end else begin
      for (fl = 1; fl <= NUM_FLOORS; fl++) begin
        if (fl < car_floor) down_sum += floor_weight[fl];
        else if (fl > car_floor) up_sum += floor_weight[fl];
      end
      // keep going while work lies ahead, else turn or stop
      case (car_dir)
        DIR_UP: begin
          car_dir = (up_sum != 0) ? DIR_UP : ((down_sum != 0) ? DIR_DOWN : DIR_STOP);
        end
        DIR_DOWN: begin
          car_dir = (down_sum != 0) ? DIR_DOWN : ((up_sum != 0) ? DIR_UP : DIR_STOP);
        end
        default: begin
          // stopped: heavier side wins, a nonzero tie goes up
          if (down_sum > up_sum) car_dir = DIR_DOWN;
          else if (up_sum > down_sum) car_dir = DIR_UP;
          else car_dir = (up_sum != 0) ? DIR_UP : DIR_STOP;
        end
      endcase
      if (car_dir == DIR_UP && car_floor < NUM_FLOORS) car_floor = car_floor + 1'b1;
      else if (car_dir == DIR_DOWN && car_floor > 1) car_floor = car_floor - 1'b1;
      // stopped on a requested floor: open the door and serve it
      if (car_dir == DIR_STOP && floor_weight[car_floor] != '0) begin
        floor_weight[car_floor] = '0;
        v.door_open = 1'b1;
        doors_opened++;
      end
    end
    v.floor    = car_floor;
    v.move_dir = car_dir;
    return v;
  endfunction

  // true once a tick would neither move the car nor open the door
  function automatic bit car_parked();
    bit quiet;
    quiet = (car_dir == DIR_STOP);
    foreach (floor_weight[i]) if (floor_weight[i] != '0) quiet = 1'b0;
    return quiet;
  endfunction

  function automatic call_beat_t make_beat(logic rt, int unsigned id, int unsigned data);
    call_beat_t b;
    b.req_type  = rt;
    b.msg_id    = id[ID_W-1:0];
    b.data_byte = data[DATA_W-1:0];
    return b;
  endfunction

  // tick with junk in the message fields, which the block must ignore
  function automatic call_beat_t tick_beat();
    return make_beat(REQ_TICK, $urandom_range(0, 2047), $urandom_range(0, 255));
  endfunction

  // mostly well-formed traffic: ticks, car calls and hall calls, some noise
  function automatic call_beat_t random_call_beat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return tick_beat();
    if (pick < 65) return make_beat(REQ_MSG, CALL_BASE_ID,
                                    ASCII_ZERO + $urandom_range(1, NUM_FLOORS));
    if (pick < 85) return make_beat(REQ_MSG, CALL_BASE_ID + $urandom_range(1, NUM_FLOORS),
                                    $urandom_range(0, 255));
    if (pick < 92) return make_beat(REQ_MSG, CALL_BASE_ID, $urandom_range(0, 255));
    return make_beat(REQ_MSG, $urandom_range(0, 2047), $urandom_range(0, 255));
  endfunction

  // drive one input beat after a random gap, predict its result on acceptance
  task automatic offer_call(input call_beat_t b);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= b.req_type;
    msg_id    <= b.msg_id;
    data_byte <= b.data_byte;
    do @(posedge clk); while (!in_ready);
    predicted_car_q.push_back(next_car_view(b));
    beats_sent++;
  endtask

  // stop offering and wait for every predicted result beat to come back
  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (predicted_car_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (predicted_car_q.size() != 0) begin
      $error("%0d result beats never arrived", predicted_car_q.size());
      mismatch_count++;
      predicted_car_q.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // apb read: setup cycle, then access cycle sampled when pready is high
  task automatic check_weight_reg(input logic reg_idx, input logic [WEIGHT_W-1:0] value);
    logic [APB_DW-1:0] want;
    logic [APB_DW-1:0] readback;
    want = '0;
    want[WEIGHT_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== want) begin
      $error("weight register %0d mismatch: expected %0d, actual %0d", reg_idx, want, readback);
      mismatch_count++;
    end
  endtask

  // apb write followed by a read back of the same register
  task automatic write_weight_reg(input logic reg_idx, input logic [WEIGHT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= APB_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_CAR_WEIGHT) car_wt_cfg = value;
    else hall_wt_cfg = value;
    check_weight_reg(reg_idx, value);
  endtask

  // weights only change with the block idle
  task automatic apply_weights(input logic [WEIGHT_W-1:0] car_w,
                               input logic [WEIGHT_W-1:0] hall_w);
    drain_results();
    write_weight_reg(REG_CAR_WEIGHT, car_w);
    write_weight_reg(REG_HALL_WEIGHT, hall_w);
    weight_settings++;
  endtask

  // tick until no request is left and the car stands still
  task automatic park_car();
    int n;
    for (n = 0; n < PARK_LIMIT && !car_parked(); n++) offer_call(tick_beat());
  endtask

  task automatic test_register_reset();
    check_weight_reg(REG_CAR_WEIGHT, CAR_WEIGHT_RST);
    check_weight_reg(REG_HALL_WEIGHT, HALL_WEIGHT_RST);
  endtask

  // out-of-range calls, floor extremes, door on the current floor, full sweep
  task automatic test_directed_calls();
    offer_call(tick_beat());                                                // nothing pending
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID, ASCII_ZERO));               // digit zero
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID, ASCII_ZERO + NUM_FLOORS + 1));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID, 0));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID, 255));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID + NUM_FLOORS + 1, ASCII_ZERO + 1));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID - 1, 0));
    offer_call(make_beat(REQ_MSG, 0, ASCII_ZERO + 5));
    offer_call(make_beat(REQ_MSG, 2047, 255));
    // a tick that looks like a car call must not register one
    offer_call(make_beat(REQ_TICK, CALL_BASE_ID, ASCII_ZERO + 3));
    // call for the floor the car stands on, then a tick opens the door
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID, ASCII_ZERO + 1));
    offer_call(tick_beat());
    // top and bottom floors, both call kinds
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID, ASCII_ZERO + NUM_FLOORS));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID + 1, 0));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID + NUM_FLOORS, 255));
    repeat (10) offer_call(tick_beat());
  endtask

  // saturation at the top weight and calls that add nothing at weight zero
  task automatic test_weight_extremes();
    apply_weights(WEIGHT_MAX, '0);
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID, ASCII_ZERO + 5));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID, ASCII_ZERO + 5));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID + 5, 0));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID + NUM_FLOORS, 0));
    repeat (3) offer_call(tick_beat());
    apply_weights('0, WEIGHT_MAX);
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID, ASCII_ZERO + 2));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID + 2, 0));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID + 2, 0));
    repeat (3) offer_call(tick_beat());
  endtask

  // stopped car between two equal requests must head up
  task automatic test_tie_break();
    int f;
    apply_weights(CAR_WEIGHT_RST, 7'd3);
    park_car();
    if (car_floor == 1 || car_floor == NUM_FLOORS) begin
      offer_call(make_beat(REQ_MSG, CALL_BASE_ID, ASCII_ZERO + (NUM_FLOORS + 1) / 2));
      park_car();
    end
    f = car_floor;
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID + f - 1, 0));
    offer_call(make_beat(REQ_MSG, CALL_BASE_ID + f + 1, 0));
    repeat (4) offer_call(tick_beat());
  endtask

  // receiver holds off for a long stretch while beats keep coming
  task automatic test_output_backpressure();
    drain_results();
    tx_idle_en     = 1'b0;
    rx_hold_cycles = HOLD_CYCLES;
    repeat (24) offer_call(random_call_beat());
    drain_results();
    tx_idle_en = 1'b1;
  endtask

  // bulk traffic over several weight settings and idle patterns
  task automatic test_random_traffic();
    int                  phase;
    logic [WEIGHT_W-1:0] cw;
    logic [WEIGHT_W-1:0] hw;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       begin cw = CAR_WEIGHT_RST; hw = HALL_WEIGHT_RST; end
        1:       begin cw = '0;             hw = WEIGHT_MAX;      end
        2:       begin cw = WEIGHT_MAX;     hw = '0;              end
        3:       begin cw = 7'd1;           hw = 7'd1;            end
        default: begin
          cw = $urandom_range(0, 127);
          hw = $urandom_range(0, 127);
        end
      endcase
      apply_weights(cw, hw);
      // alternate which side idles, one phase with no idling at all
      tx_idle_en = (phase != 1) && (phase != 5);
      rx_idle_en = (phase != 2) && (phase != 5);
      repeat (PHASE_BEATS) offer_call(random_call_beat());
    end
    drain_results();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // result side: random stall per beat, then compare against the oldest prediction
  initial begin : result_monitor
    int        stall;
    car_view_t want;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (predicted_car_q.size() == 0) begin
        $error("result beat with nothing pending: floor %0d", floor);
        mismatch_count++;
      end else begin
        want = predicted_car_q.pop_front();
        if (floor !== want.floor) begin
          $error("floor mismatch: expected %0d, actual %0d", want.floor, floor);
          mismatch_count++;
        end
        if (move_dir !== want.move_dir) begin
          $error("move_dir mismatch: expected %0d, actual %0d", want.move_dir, move_dir);
          mismatch_count++;
        end
        if (door_open !== want.door_open) begin
          $error("door_open mismatch: expected %0d, actual %0d", want.door_open, door_open);
          mismatch_count++;
        end
        if (call_ignored !== want.call_ignored) begin
          $error("call_ignored mismatch: expected %0d, actual %0d",
                 want.call_ignored, call_ignored);
          mismatch_count++;
        end
        results_checked++;
      end
    end
  end

  // main sequence
  initial begin
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    req_type  <= REQ_TICK;
    msg_id    <= '0;
    data_byte <= '0;
    // expected state right after reset
    foreach (floor_weight[i]) floor_weight[i] = '0;
    car_floor   = 1;
    car_dir     = DIR_STOP;
    car_wt_cfg  = CAR_WEIGHT_RST;
    hall_wt_cfg = HALL_WEIGHT_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_reset();
    test_directed_calls();
    test_weight_extremes();
    test_tie_break();
    test_output_backpressure();
    test_random_traffic();

    drain_results();
    $display("run covered %0d input beats and %0d result beats over %0d weight settings",
             beats_sent, results_checked, weight_settings);
    $display("%0d door openings, %0d ignored calls, %0d saturated adds, %0d input stall cycles",
             doors_opened, ignored_calls, saturated_adds, input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
